FILE: design/afoc_pkg.sv
// ----------------------------------------------------------------------------
// afoc_pkg - shared types and constants of the frame offset calibrator
// Field widths, lane control group and beat kind codes.
// ----------------------------------------------------------------------------
package afoc_pkg;

   localparam int MAX_CH = 8;
   localparam int RAW_W  = 24;
   localparam int OUT_W  = 25;
   localparam int SUM_W  = 40;
   localparam int CNT_W  = 16;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_CAL  = 1'b1;

   typedef logic [RAW_W-1:0]        raw_type;
   typedef logic signed [RAW_W-1:0] offset_type;
   typedef logic signed [OUT_W-1:0] out_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [SUM_W-1:0]        mag_type;
   typedef logic [CNT_W-1:0]        cnt_type;

   typedef struct packed {
      logic clear;
      logic accumulate;
      logic start_div;
   } lane_ctrl_type;

endpackage

FILE: design/afoc_channels.sv
// ----------------------------------------------------------------------------
// afoc channels - frame request and corrected frame response interfaces
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface afoc_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   afoc_pkg::raw_type  ch0_raw;
   afoc_pkg::raw_type  ch1_raw;
   afoc_pkg::raw_type  ch2_raw;
   afoc_pkg::raw_type  ch3_raw;
   afoc_pkg::raw_type  ch4_raw;
   afoc_pkg::raw_type  ch5_raw;
   afoc_pkg::raw_type  ch6_raw;
   afoc_pkg::raw_type  ch7_raw;

   modport source (output valid, kind, ch0_raw, ch1_raw, ch2_raw, ch3_raw,
                   ch4_raw, ch5_raw, ch6_raw, ch7_raw, input ready);
   modport sink   (input valid, kind, ch0_raw, ch1_raw, ch2_raw, ch3_raw,
                   ch4_raw, ch5_raw, ch6_raw, ch7_raw, output ready);
endinterface

interface afoc_rsp_if;
   logic               valid;
   logic               ready;
   afoc_pkg::out_type  ch0_out;
   afoc_pkg::out_type  ch1_out;
   afoc_pkg::out_type  ch2_out;
   afoc_pkg::out_type  ch3_out;
   afoc_pkg::out_type  ch4_out;
   afoc_pkg::out_type  ch5_out;
   afoc_pkg::out_type  ch6_out;
   afoc_pkg::out_type  ch7_out;
   logic               in_calibration;
   logic               offsets_updated;

   modport source (output valid, ch0_out, ch1_out, ch2_out, ch3_out, ch4_out,
                   ch5_out, ch6_out, ch7_out, in_calibration, offsets_updated,
                   input ready);
   modport sink   (input valid, ch0_out, ch1_out, ch2_out, ch3_out, ch4_out,
                   ch5_out, ch6_out, ch7_out, in_calibration, offsets_updated,
                   output ready);
endinterface

FILE: design/afoc_div.sv
// ----------------------------------------------------------------------------
// afoc_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle over the full sum width.
// ----------------------------------------------------------------------------
module afoc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  afoc_pkg::mag_type             dividend,
   input  afoc_pkg::cnt_type             divisor,
   output logic [afoc_pkg::RAW_W-1:0]    quotient,
   output logic                          busy,
   output logic                          done
);

   localparam int STEP_W = $clog2(afoc_pkg::SUM_W);

   afoc_pkg::mag_type  quo_ff, quo_in;
   afoc_pkg::cnt_type  rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [afoc_pkg::CNT_W:0] shifted;
   logic               fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[afoc_pkg::SUM_W-1]};
      fits    = shifted >= {1'b0, divisor};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         step_in = STEP_W'(afoc_pkg::SUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[afoc_pkg::SUM_W-2:0], fits};
         rem_in = fits ? afoc_pkg::CNT_W'(shifted - {1'b0, divisor})
                       : shifted[afoc_pkg::CNT_W-1:0];
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign quotient = quo_ff[afoc_pkg::RAW_W-1:0];
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

FILE: design/afoc_lane.sv
// ----------------------------------------------------------------------------
// afoc_lane - one channel of the calibrator
// Offset subtraction, calibration sum and the offset divider of one channel.
// ----------------------------------------------------------------------------
module afoc_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  afoc_pkg::lane_ctrl_type  ctrl,
   input  afoc_pkg::raw_type        raw,
   input  afoc_pkg::cnt_type        divisor,
   output afoc_pkg::out_type        diff,
   output logic                     busy
);

   afoc_pkg::sum_type     sum_ff, sum_in;
   afoc_pkg::offset_type  offset_ff, offset_in;
   logic                  neg_ff, neg_in;
   afoc_pkg::mag_type     magnitude;
   logic [afoc_pkg::RAW_W-1:0] quotient;
   logic                  div_busy;
   logic                  div_done;

   assign diff = $signed({raw[afoc_pkg::RAW_W-1], raw})
               - $signed({offset_ff[afoc_pkg::RAW_W-1], offset_ff});

   assign magnitude = sum_ff[afoc_pkg::SUM_W-1] ? afoc_pkg::mag_type'(-sum_ff)
                                                : afoc_pkg::mag_type'(sum_ff);

   afoc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.start_div),
      .dividend (magnitude),
      .divisor  (divisor),
      .quotient (quotient),
      .busy     (div_busy),
      .done     (div_done)
   );

   always_comb begin
      sum_in    = sum_ff;
      offset_in = offset_ff;
      neg_in    = neg_ff;
      if (ctrl.clear) begin
         sum_in    = '0;
         offset_in = '0;
      end else if (ctrl.accumulate) begin
         sum_in = sum_ff + {{(afoc_pkg::SUM_W-afoc_pkg::OUT_W){diff[afoc_pkg::OUT_W-1]}},
                            diff};
      end
      if (ctrl.start_div) begin
         neg_in = sum_ff[afoc_pkg::SUM_W-1];
      end
      if (div_done) begin
         offset_in = neg_ff ? afoc_pkg::offset_type'(-quotient)
                            : afoc_pkg::offset_type'(quotient);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         offset_ff <= '0;
      end else begin
         sum_ff    <= sum_in;
         offset_ff <= offset_in;
      end
      neg_ff <= neg_in;
   end

   assign busy = div_busy || div_done;

endmodule

FILE: design/afoc_merge.sv
// ----------------------------------------------------------------------------
// afoc_merge - response stage
// Collects the lane results and status flags into the registered response beat.
// ----------------------------------------------------------------------------
module afoc_merge (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  afoc_pkg::out_type  diff [afoc_pkg::MAX_CH],
   input  logic               in_calibration,
   input  logic               offsets_updated,
   output logic               space,
   afoc_rsp_if.source         rsp_chan
);

   logic               valid_ff, valid_in;
   afoc_pkg::out_type  data_ff [afoc_pkg::MAX_CH];
   logic               cal_ff;
   logic               upd_ff;

   assign space = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= diff;
         cal_ff  <= in_calibration;
         upd_ff  <= offsets_updated;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.ch0_out         = data_ff[0];
   assign rsp_chan.ch1_out         = data_ff[1];
   assign rsp_chan.ch2_out         = data_ff[2];
   assign rsp_chan.ch3_out         = data_ff[3];
   assign rsp_chan.ch4_out         = data_ff[4];
   assign rsp_chan.ch5_out         = data_ff[5];
   assign rsp_chan.ch6_out         = data_ff[6];
   assign rsp_chan.ch7_out         = data_ff[7];
   assign rsp_chan.in_calibration  = cal_ff;
   assign rsp_chan.offsets_updated = upd_ff;

endmodule

FILE: design/adc_frame_offset_calibrator_core.sv
// ----------------------------------------------------------------------------
// adc_frame_offset_calibrator_core - per-channel offset removal and calibration
// Subtracts a stored offset from each channel of a frame; averages frames to
// learn the offsets on request.
// ----------------------------------------------------------------------------
// req_chan takes one beat per frame: kind selects a data frame or a start of
// calibration. A data frame returns one rsp_chan beat holding each channel
// minus its offset plus two flags; a start beat returns nothing, clears all
// offsets and sums and opens a calibration of csr_write_data frames (written
// through csr_write_en while idle, reset value 1, zero acts as one).
// A data frame is answered in the cycle after acceptance from the response
// register, and frames are taken every cycle while that register drains and
// no divider is busy. The frame that closes a calibration starts each used
// lane's divider, restoring division one bit per cycle over the 40-bit sums:
// req_chan.ready stays low until they finish, then the new offsets apply.
// Reset clears offsets, sums, the frame count and calibration, and sets the
// calibration length to 1. When rsp_chan stalls with a beat waiting,
// req_chan.ready drops until the beat is taken; no beat is dropped.
// ----------------------------------------------------------------------------
module adc_frame_offset_calibrator_core #(
   parameter int CHANNELS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   afoc_req_if.sink                  req_chan,
   afoc_rsp_if.source                rsp_chan,
   input  logic                      csr_write_en,
   input  afoc_pkg::cnt_type         csr_write_data
);

   afoc_pkg::cnt_type  cal_samples_ff, cal_samples_in;
   afoc_pkg::cnt_type  frames_ff, frames_in;
   logic               calibrating_ff, calibrating_in;
   logic               div_pend_ff, div_pend_in;

   afoc_pkg::raw_type  raw [afoc_pkg::MAX_CH];
   afoc_pkg::out_type  diff [afoc_pkg::MAX_CH];
   logic [afoc_pkg::MAX_CH-1:0] lane_busy;
   afoc_pkg::lane_ctrl_type ctrl;
   afoc_pkg::cnt_type  frames_next;
   logic               accept;
   logic               is_data;
   logic               summed;
   logic               updated;
   logic               space;
   logic               busy;

   assign raw[0] = req_chan.ch0_raw;
   assign raw[1] = req_chan.ch1_raw;
   assign raw[2] = req_chan.ch2_raw;
   assign raw[3] = req_chan.ch3_raw;
   assign raw[4] = req_chan.ch4_raw;
   assign raw[5] = req_chan.ch5_raw;
   assign raw[6] = req_chan.ch6_raw;
   assign raw[7] = req_chan.ch7_raw;

   assign busy           = div_pend_ff || (|lane_busy);
   assign req_chan.ready = !busy && space;
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_data        = req_chan.kind == afoc_pkg::KIND_DATA;

   always_comb begin
      frames_next    = (frames_ff == '1) ? frames_ff : frames_ff + 1'b1;
      cal_samples_in = csr_write_en ? csr_write_data : cal_samples_ff;
      frames_in      = frames_ff;
      calibrating_in = calibrating_ff;
      div_pend_in    = 1'b0;
      summed         = 1'b0;
      updated        = 1'b0;
      ctrl           = '0;
      ctrl.start_div = div_pend_ff;
      if (accept) begin
         if (!is_data) begin
            ctrl.clear     = 1'b1;
            frames_in      = '0;
            calibrating_in = 1'b1;
         end else if (calibrating_ff) begin
            summed          = 1'b1;
            ctrl.accumulate = 1'b1;
            frames_in       = frames_next;
            if (frames_next >= cal_samples_ff) begin
               calibrating_in = 1'b0;
               div_pend_in    = 1'b1;
               updated        = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_samples_ff <= afoc_pkg::CNT_W'(1);
         frames_ff      <= '0;
         calibrating_ff <= 1'b0;
         div_pend_ff    <= 1'b0;
      end else begin
         cal_samples_ff <= cal_samples_in;
         frames_ff      <= frames_in;
         calibrating_ff <= calibrating_in;
         div_pend_ff    <= div_pend_in;
      end
   end

   for (genvar g = 0; g < afoc_pkg::MAX_CH; g++) begin : g_lane
      if (g < CHANNELS) begin : g_used
         afoc_lane u_lane (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (ctrl),
            .raw     (raw[g]),
            .divisor (frames_ff),
            .diff    (diff[g]),
            .busy    (lane_busy[g])
         );
      end else begin : g_unused
         assign diff[g]      = '0;
         assign lane_busy[g] = 1'b0;
      end
   end

   afoc_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .load            (accept && is_data),
      .diff            (diff),
      .in_calibration  (summed),
      .offsets_updated (updated),
      .space           (space),
      .rsp_chan        (rsp_chan)
   );

endmodule
